@@ design/ipr_pkg.sv @@
// types and constants shared by the index page row table
package ipr_pkg;

    localparam int KEY_W       = 64;
    localparam int ROW_COUNT_W = 7;
    localparam int INDEX_W     = 6;
    localparam int OP_W        = 2;

    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ     = 2'd1;
    localparam logic [OP_W-1:0] OP_TRUNCATE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   value_pos;
        logic [INDEX_W-1:0] index;
    } t_in;

    typedef struct packed {
        logic                   ok;
        logic [KEY_W-1:0]       key_out;
        logic [KEY_W-1:0]       value_out;
        logic [ROW_COUNT_W-1:0] row_count;
        logic [KEY_W-1:0]       min_key_out;
        logic [KEY_W-1:0]       max_key_out;
        logic                   full_res;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] value;
    } t_row;

endpackage

@@ design/ipr_row_mem.sv @@
// row storage: one write port, one read port with registered read data
module ipr_row_mem
    import ipr_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_row          i_wr_row,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_row          o_rd_row
);

    t_row r_mem [DEPTH];
    t_row r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

@@ design/index_page_row_table.sv @@
// index page row table: control sequencer, bounds registers and output register
//
// A bounded table of up to PAGE_ROWS rows, each a 64-bit key with a 64-bit value
// position, kept in one synchronous row memory, with a row count and running
// minimum and maximum keys in registers. One item is worked on at a time and
// every item gives exactly one result. Insert, read and the unused operation code
// go from transfer through the done state to a registered result (an insert writes
// its row at transfer, a read takes its row from the registered memory read data).
// A truncate first scans its rows, reading one row per cycle through the single
// memory read port. The input is ready again once the result has moved into the
// output register. Rows need no clearing after reset: a row at or past the count
// is never reported.
module index_page_row_table
    import ipr_pkg::*;
#(
    parameter int PAGE_ROWS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int AW    = (PAGE_ROWS > 1) ? $clog2(PAGE_ROWS) : 1;
    localparam int CW    = $clog2(PAGE_ROWS + 1);
    localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_total, n_total;
    logic [KEY_W-1:0] r_low, n_low;
    logic [KEY_W-1:0] r_high, n_high;
    logic [CW-1:0]    r_scan, n_scan;
    logic [KEY_W-1:0] r_last, n_last;
    logic [OP_W-1:0]  r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_ok, n_ok;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    logic          accept;
    logic          full;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] scan_next;
    t_row          wr_row;
    t_row          rd_row;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_total == CW'(PAGE_ROWS));
    assign scan_next  = r_total == '0 ? '0 : r_scan + CW'(1);
    assign wr_row     = '{key: i_in.key, value: i_in.value_pos};

    ipr_row_mem #(
        .DEPTH (PAGE_ROWS),
        .AW    (AW)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_total[AW-1:0]),
        .i_wr_row  (wr_row),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_row  (rd_row)
    );

    always_comb begin
        logic [CW-1:0] kept;
        logic          finish;

        n_state     = r_state;
        n_total     = r_total;
        n_low       = r_low;
        n_high      = r_high;
        n_scan      = r_scan;
        n_last      = r_last;
        n_op        = r_op;
        n_key       = r_key;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        kept        = r_scan;
        finish      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_in.operation;
                    n_key   = i_in.key;
                    n_scan  = '0;
                    n_last  = '0;
                    n_state = S_DONE;
                    case (i_in.operation)
                        OP_INSERT: begin
                            n_ok = !full;
                            if (!full) begin
                                wr_en   = 1'b1;
                                n_total = r_total + CW'(1);
                                if (r_total == '0) begin
                                    n_low  = i_in.key;
                                    n_high = i_in.key;
                                end else if (r_low > i_in.key) begin
                                    n_low = i_in.key;
                                end else if (r_high < i_in.key) begin
                                    n_high = i_in.key;
                                end
                            end
                        end
                        OP_READ: begin
                            n_ok    = CMP_W'(i_in.index) < CMP_W'(r_total);
                            rd_en   = 1'b1;
                            rd_addr = AW'(i_in.index);
                        end
                        OP_TRUNCATE: begin
                            n_ok = 1'b1;
                            if (r_total == '0) begin
                                n_low  = '0;
                                n_high = '0;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // rd_row holds the key of row r_scan
                if (rd_row.key < r_key) begin
                    n_last = rd_row.key;
                    if (scan_next < r_total) begin
                        n_scan  = scan_next;
                        rd_en   = 1'b1;
                        rd_addr = scan_next[AW-1:0];
                    end else begin
                        finish = 1'b1;
                        kept   = scan_next;
                    end
                end else begin
                    finish = 1'b1;
                    kept   = r_scan;
                end
                if (finish) begin
                    n_total = kept;
                    n_high  = n_last;
                    if (kept == '0) begin
                        n_low = '0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.ok          = r_ok;
                    n_out.key_out     = (r_op == OP_READ && r_ok) ? rd_row.key : '0;
                    n_out.value_out   = (r_op == OP_READ && r_ok) ? rd_row.value : '0;
                    n_out.row_count   = ROW_COUNT_W'(r_total);
                    n_out.min_key_out = r_low;
                    n_out.max_key_out = r_high;
                    n_out.full_res    = full;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_low       <= n_low;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_last <= n_last;
        r_op   <= n_op;
        r_key  <= n_key;
        r_ok   <= n_ok;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(PAGE_ROWS))
        else $error("row count exceeds page capacity");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.operation == OP_INSERT && !full)
        |=> r_total == $past(r_total) + CW'(1))
        else $error("accepted insert did not add a row");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan < r_total))
        else $error("truncate scan past the row count");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result dropped while output register busy");

endmodule
